@@ rtl/aahd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aahd_pkg;

    // Width of the sample value; thresholds are always 32 bits
    localparam int VALUE_W = 32;
    localparam int LEVEL_W = 32;
    localparam int BAND_W  = 31;
    localparam int SEVMAP_W = 10;
    // Wide enough for either the value or a threshold
    localparam int WIDE_W  = (VALUE_W > LEVEL_W) ? VALUE_W : LEVEL_W;
    // Room for an exact difference of two wide operands plus a sign
    localparam int EXT_W   = WIDE_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIHI = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOLO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYST       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MON_DB     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_DB     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEV_MAP    = 3'd7;

    // Outcome codes of a processing pass
    localparam logic [1:0] OUT_OK        = 2'd0;
    localparam logic [1:0] OUT_SUB_ERR   = 2'd1;
    localparam logic [1:0] OUT_NO_SUB    = 2'd2;
    localparam logic [1:0] OUT_FETCH_BAD = 2'd3;

    // Alarm status codes
    localparam logic [2:0] STA_NONE    = 3'd0;
    localparam logic [2:0] STA_UNDEF   = 3'd1;
    localparam logic [2:0] STA_HIHI    = 3'd2;
    localparam logic [2:0] STA_LOLO    = 3'd3;
    localparam logic [2:0] STA_HIGH    = 3'd4;
    localparam logic [2:0] STA_LOW     = 3'd5;
    localparam logic [2:0] STA_SOFT    = 3'd6;
    localparam logic [2:0] STA_BAD_SUB = 3'd7;

    // Alarm severity codes
    localparam logic [1:0] SEV_NONE    = 2'd0;
    localparam logic [1:0] SEV_MINOR   = 2'd1;
    localparam logic [1:0] SEV_MAJOR   = 2'd2;
    localparam logic [1:0] SEV_INVALID = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [EXT_W-1:0]   t_ext;

    typedef struct packed {
        t_value     value;
        logic [1:0] outcome;
    } t_in;

    typedef struct packed {
        t_value     value_out;
        logic [2:0] alarm_status;
        logic [1:0] alarm_severity;
        logic       value_event;
        logic       archive_event;
        logic       alarm_event;
    } t_out;

    typedef struct packed {
        t_level              level_hihi;
        t_level              level_high;
        t_level              level_low;
        t_level              level_lolo;
        logic [BAND_W-1:0]   hysteresis;
        logic [BAND_W-1:0]   monitor_deadband;
        logic [BAND_W-1:0]   archive_deadband;
        logic [SEVMAP_W-1:0] severity_map;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/aahd_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aahd_cfg
    import aahd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEVEL_HIHI: r_cfg.level_hihi       <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_HIGH: r_cfg.level_high       <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_LOW:  r_cfg.level_low        <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_LOLO: r_cfg.level_lolo       <= i_cfg_data[LEVEL_W-1:0];
                REG_HYST:       r_cfg.hysteresis       <= i_cfg_data[BAND_W-1:0];
                REG_MON_DB:     r_cfg.monitor_deadband <= i_cfg_data[BAND_W-1:0];
                REG_ARC_DB:     r_cfg.archive_deadband <= i_cfg_data[BAND_W-1:0];
                REG_SEV_MAP:    r_cfg.severity_map     <= i_cfg_data[SEVMAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/aahd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aahd_core
    import aahd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_in  i_item,
    input  wire t_cfg i_cfg,
    output t_out      o_result
);

    // Persistent alarm state
    logic       r_undef;
    t_value     r_held;
    t_wide      r_last_lvl;
    t_value     r_last_mon;
    t_value     r_last_arc;
    logic [1:0] r_cur_sev;
    logic [2:0] r_cur_sta;

    logic       n_undef;
    t_value     n_held;
    t_wide      n_last_lvl;
    t_value     n_last_mon;
    t_value     n_last_arc;

    logic [1:0] pend_sev;
    logic [2:0] pend_sta;
    logic [1:0] sev_hihi, sev_high, sev_low, sev_lolo, sev_sub;
    t_ext       v_x, hihi_x, high_x, low_x, lolo_x, hyst_x;
    t_wide      v_w;
    logic       hit_hihi, hit_lolo, hit_high, hit_low;
    logic       lvl_hit;
    logic [1:0] lvl_sev;
    logic [2:0] lvl_sta;
    t_wide      lvl_val;
    t_ext       mon_diff, arc_diff, mon_abs, arc_abs;
    logic       value_ev, archive_ev, alarm_ev;

    assign sev_hihi = i_cfg.severity_map[1:0];
    assign sev_high = i_cfg.severity_map[3:2];
    assign sev_low  = i_cfg.severity_map[5:4];
    assign sev_lolo = i_cfg.severity_map[7:6];
    assign sev_sub  = i_cfg.severity_map[9:8];

    assign hihi_x = t_ext'(i_cfg.level_hihi);
    assign high_x = t_ext'(i_cfg.level_high);
    assign low_x  = t_ext'(i_cfg.level_low);
    assign lolo_x = t_ext'(i_cfg.level_lolo);
    assign hyst_x = t_ext'({1'b0, i_cfg.hysteresis});

    // Apply the outcome: store or drop the value, raise outcome alarms
    always_comb begin
        n_undef  = r_undef;
        n_held   = r_held;
        pend_sev = SEV_NONE;
        pend_sta = STA_NONE;
        case (i_item.outcome)
            OUT_OK: begin
                n_held  = i_item.value;
                n_undef = 1'b0;
            end
            OUT_SUB_ERR: begin
                n_held = i_item.value;
                if (sev_sub != SEV_NONE) begin
                    pend_sev = sev_sub;
                    pend_sta = STA_SOFT;
                end
            end
            OUT_NO_SUB: begin
                pend_sev = SEV_INVALID;
                pend_sta = STA_BAD_SUB;
            end
            default: ;
        endcase
    end

    assign v_x = t_ext'(n_held);
    assign v_w = t_wide'(n_held);

    // Level tests; the active level releases only past the hysteresis margin
    always_comb begin
        hit_hihi = (sev_hihi != SEV_NONE) &&
                   ((r_last_lvl == t_wide'(i_cfg.level_hihi)) ?
                    (hihi_x - v_x <= hyst_x) : (v_x >= hihi_x));
        hit_lolo = (sev_lolo != SEV_NONE) &&
                   ((r_last_lvl == t_wide'(i_cfg.level_lolo)) ?
                    (v_x - lolo_x <= hyst_x) : (lolo_x >= v_x));
        hit_high = (sev_high != SEV_NONE) &&
                   ((r_last_lvl == t_wide'(i_cfg.level_high)) ?
                    (high_x - v_x <= hyst_x) : (v_x >= high_x));
        hit_low  = (sev_low != SEV_NONE) &&
                   ((r_last_lvl == t_wide'(i_cfg.level_low)) ?
                    (v_x - low_x <= hyst_x) : (low_x >= v_x));
    end

    // Pick the first level that fires, in HIHI, LOLO, HIGH, LOW order
    always_comb begin
        lvl_hit = 1'b1;
        lvl_sev = sev_hihi;
        lvl_sta = STA_HIHI;
        lvl_val = t_wide'(i_cfg.level_hihi);
        if (hit_hihi) begin
            lvl_sev = sev_hihi;
        end else if (hit_lolo) begin
            lvl_sev = sev_lolo;
            lvl_sta = STA_LOLO;
            lvl_val = t_wide'(i_cfg.level_lolo);
        end else if (hit_high) begin
            lvl_sev = sev_high;
            lvl_sta = STA_HIGH;
            lvl_val = t_wide'(i_cfg.level_high);
        end else if (hit_low) begin
            lvl_sev = sev_low;
            lvl_sta = STA_LOW;
            lvl_val = t_wide'(i_cfg.level_low);
        end else begin
            lvl_hit = 1'b0;
        end
    end

    // Merge level or undefined alarm into the pending pair
    logic [1:0] fin_sev;
    logic [2:0] fin_sta;

    always_comb begin
        fin_sev    = pend_sev;
        fin_sta    = pend_sta;
        n_last_lvl = r_last_lvl;
        if (n_undef) begin
            if (SEV_INVALID > pend_sev) begin
                fin_sev = SEV_INVALID;
                fin_sta = STA_UNDEF;
            end
        end else if (lvl_hit) begin
            if (lvl_sev > pend_sev) begin
                fin_sev    = lvl_sev;
                fin_sta    = lvl_sta;
                n_last_lvl = lvl_val;
            end
        end else begin
            n_last_lvl = v_w;
        end
    end

    assign alarm_ev = (fin_sev != r_cur_sev) || (fin_sta != r_cur_sta);

    // Deadband checks against the last reported values
    assign mon_diff = v_x - t_ext'(r_last_mon);
    assign arc_diff = v_x - t_ext'(r_last_arc);
    assign mon_abs  = mon_diff[EXT_W-1] ? -mon_diff : mon_diff;
    assign arc_abs  = arc_diff[EXT_W-1] ? -arc_diff : arc_diff;
    assign value_ev   = mon_abs > t_ext'({1'b0, i_cfg.monitor_deadband});
    assign archive_ev = arc_abs > t_ext'({1'b0, i_cfg.archive_deadband});
    assign n_last_mon = value_ev ? n_held : r_last_mon;
    assign n_last_arc = archive_ev ? n_held : r_last_arc;

    // Commit state on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undef    <= 1'b1;
            r_held     <= '0;
            r_last_lvl <= '0;
            r_last_mon <= '0;
            r_last_arc <= '0;
            r_cur_sev  <= SEV_NONE;
            r_cur_sta  <= STA_NONE;
        end else if (i_fire) begin
            r_undef    <= n_undef;
            r_held     <= n_held;
            r_last_lvl <= n_last_lvl;
            r_last_mon <= n_last_mon;
            r_last_arc <= n_last_arc;
            r_cur_sev  <= fin_sev;
            r_cur_sta  <= fin_sta;
        end
    end

    always_comb begin
        o_result.value_out      = n_held;
        o_result.alarm_status   = fin_sta;
        o_result.alarm_severity = fin_sev;
        o_result.value_event    = value_ev;
        o_result.archive_event  = archive_ev;
        o_result.alarm_event    = alarm_ev;
    end

endmodule

`default_nettype wire

@@ rtl/analog_alarm_hysteresis_deadband.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Four-level analog alarm with hysteresis and value/archive deadbands.
// Input channel: i_in_valid / o_in_stall carry one request (value, outcome)
// per processing pass. Output channel: o_out_valid / i_out_stall carry one
// result per request, in order. A transfer happens on a rising edge with
// valid high and stall low.
// Each accepted request waits in the input register until the result register
// is free, then is processed into the result register and shown from there.
// Throughput: one request per cycle while the receiver does not stall; the
// whole pass is a single compare and select stage between the input register
// and the result register. When the receiver stalls, the result register
// holds and one more request is taken into the input register only if it is
// empty; stall then reaches the sender.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at a
// rising edge; write only while no request is in flight.
// Reset (synchronous, active low) empties both registers, clears all
// thresholds, bands and severities to zero and marks the value undefined.

module analog_alarm_hysteresis_deadband
    import aahd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_out result;
    t_in  r_in;
    logic r_in_valid;
    t_out r_out;
    logic r_out_valid;
    logic out_free;
    logic fire;
    logic in_take;

    aahd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    aahd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Handshake: process when the result slot is empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
